FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ABS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ABS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/abs_msd_pkg.sv
// Shared types and constants of the active Brownian step block.
package abs_msd_pkg;

	localparam int STEPS_DEFAULT = 16384;

	localparam logic [23:0] TRANS_RESET = 24'd24054;
	localparam logic [23:0] ROT_RESET   = 24'd530330;
	localparam logic [23:0] DRIFT_RESET = 24'd52429;

	localparam logic [1:0] REG_TRANS = 2'd0;
	localparam logic [1:0] REG_ROT   = 2'd1;
	localparam logic [1:0] REG_DRIFT = 2'd2;

	localparam logic [16:0] SIN_C1 = 17'd102944;
	localparam logic [15:0] SIN_C3 = 16'd42335;
	localparam logic [12:0] SIN_C5 = 13'd4927;

	localparam logic [62:0] ACC_MAX = {63{1'b1}};

	typedef enum logic [1:0] {
		KIND_STEP = 2'd0,
		KIND_NEW  = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic signed [15:0]  noise_x;
		logic signed [15:0]  noise_y;
		logic signed [15:0]  noise_heading;
		logic [13:0]         read_index;
	} item_t;

	typedef struct packed {
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic [31:0]         heading;
		logic [14:0]         step_number;
		logic [62:0]         accum_value;
		logic                overrun;
	} result_t;

endpackage

FILE: design/active_brownian_step_msd_top.sv
// Active Brownian particle step engine with per-step squared-distance accumulators.
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_stall        abs_msd_pkg::item_t
//  result    out        result_valid / result_stall    abs_msd_pkg::result_t
//  config    in         psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// One transaction per cycle sustained while the result is not stalled; the
// accepting edge loads stage one, and the item then passes through stages two
// to ten and the output register. The depth is set by the sine/cosine polynomial
// (four dependent multiplies) and the accumulator read-modify-write.
// The accumulator memory has no clearing pass: a fill count marks the
// written prefix, so the block takes items right after reset.
// A stalled result holds the whole pipeline; item_stall rises with it.
module active_brownian_step_msd_top #(
	parameter int STEPS = abs_msd_pkg::STEPS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  abs_msd_pkg::item_t    item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output abs_msd_pkg::result_t  result
);

	localparam int AW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int CW = $clog2(STEPS + 1);
	localparam logic [CW-1:0] STEPS_C = CW'(STEPS);

	// Side information that rides along with each item.
	typedef struct packed {
		logic [1:0]         kind;
		logic [CW-1:0]      nb;
		logic               ovr;
		logic [13:0]        rd_idx;
		logic [31:0]        heading;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} carry_t;

	// ---------------- configuration registers ----------------
	logic [23:0] trans_q, rot_q, drift_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q <= abs_msd_pkg::TRANS_RESET;
			rot_q   <= abs_msd_pkg::ROT_RESET;
			drift_q <= abs_msd_pkg::DRIFT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				abs_msd_pkg::REG_TRANS: trans_q <= pwdata[23:0];
				abs_msd_pkg::REG_ROT:   rot_q   <= pwdata[23:0];
				abs_msd_pkg::REG_DRIFT: drift_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			abs_msd_pkg::REG_TRANS: prdata = {8'd0, trans_q};
			abs_msd_pkg::REG_ROT:   prdata = {8'd0, rot_q};
			abs_msd_pkg::REG_DRIFT: prdata = {8'd0, drift_q};
			default:                prdata = 32'd0;
		endcase
	end

	// ---------------- flow control ----------------
	// Advance every stage together whenever the output register can move.
	logic        en, accept;
	logic [9:0]  stg_vld_q;

	assign en         = !result_valid || !result_stall;
	assign item_stall = !en;
	assign accept     = item_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q    <= '0;
			result_valid <= 1'b0;
		end else if (en) begin
			stg_vld_q    <= {stg_vld_q[8:0], accept};
			result_valid <= stg_vld_q[9];
		end
	end

	// ---------------- stage 1: counter, noise products ----------------
	logic [CW-1:0]       cnt_q;
	logic signed [40:0]  px, py, ph;
	logic                rd_oob;
	carry_t              c_in;
	carry_t              c_s1;
	logic signed [28:0]  dxn_s1, dyn_s1;
	logic [31:0]         dh_s1;

	assign px     = $signed({1'b0, trans_q}) * item.noise_x;
	assign py     = $signed({1'b0, trans_q}) * item.noise_y;
	assign ph     = $signed({1'b0, rot_q}) * item.noise_heading;
	assign rd_oob = {18'd0, item.read_index} >= 32'(STEPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (item.kind == abs_msd_pkg::KIND_STEP) begin
				if (cnt_q < STEPS_C) cnt_q <= cnt_q + CW'(1);
			end else if (item.kind == abs_msd_pkg::KIND_NEW) begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		c_in        = '0;
		c_in.kind   = item.kind;
		c_in.rd_idx = item.read_index;
		c_in.nb     = (item.kind == abs_msd_pkg::KIND_NEW) ? '0 : cnt_q;
		unique case (item.kind)
			abs_msd_pkg::KIND_STEP: c_in.ovr = (cnt_q >= STEPS_C);
			abs_msd_pkg::KIND_READ: c_in.ovr = rd_oob;
			default:                c_in.ovr = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= c_in;
			dxn_s1 <= px[40:12];
			dyn_s1 <= py[40:12];
			dh_s1  <= ph[35:4];
		end
	end

	// ---------------- stage 2: heading update ----------------
	logic [31:0]         heading_q, h_next;
	carry_t              c2_in;
	carry_t              c_s2;
	logic signed [28:0]  dxn_s2, dyn_s2;
	logic [31:0]         hpre_s2;

	always_comb begin
		unique case (c_s1.kind)
			abs_msd_pkg::KIND_STEP: h_next = heading_q + dh_s1;
			abs_msd_pkg::KIND_NEW:  h_next = 32'd0;
			default:                h_next = heading_q;
		endcase
	end

	always_comb begin
		c2_in         = c_s1;
		c2_in.heading = h_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) heading_q <= '0;
		else if (en && stg_vld_q[0]) heading_q <= h_next;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2    <= c2_in;
			dxn_s2  <= dxn_s1;
			dyn_s2  <= dyn_s1;
			hpre_s2 <= heading_q;
		end
	end

	// ---------------- stages 3-6: quarter-wave sine for t and 1-t ----------------
	logic [16:0]         ua, ub;
	logic [33:0]         sqa, sqb;
	carry_t              c_s3, c_s4, c_s5, c_s6;
	logic signed [28:0]  dxn_s3, dyn_s3, dxn_s4, dyn_s4, dxn_s5, dyn_s5, dxn_s6, dyn_s6;
	logic [1:0]          quad_s3, quad_s4, quad_s5, quad_s6;
	logic [16:0]         ua_s3, ub_s3, u2a_s3, u2b_s3;
	logic [16:0]         ua_s4, ub_s4, u2a_s4, u2b_s4;
	logic [15:0]         pa1_s4, pb1_s4;
	logic [29:0]         m5a, m5b;
	logic [16:0]         ua_s5, ub_s5, pa2_s5, pb2_s5;
	logic [32:0]         m3a, m3b;
	logic [33:0]         m1a, m1b;
	logic [16:0]         sa_s6, sb_s6;

	assign ua  = {1'b0, hpre_s2[29:14]};
	assign ub  = 17'd65536 - ua;
	assign sqa = ua * ua;
	assign sqb = ub * ub;
	assign m5a = abs_msd_pkg::SIN_C5 * u2a_s3;
	assign m5b = abs_msd_pkg::SIN_C5 * u2b_s3;
	assign m3a = pa1_s4 * u2a_s4;
	assign m3b = pb1_s4 * u2b_s4;
	assign m1a = pa2_s5 * ua_s5;
	assign m1b = pb2_s5 * ub_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3    <= c_s2;  dxn_s3 <= dxn_s2;  dyn_s3 <= dyn_s2;
			quad_s3 <= hpre_s2[31:30];
			ua_s3   <= ua;    ub_s3  <= ub;
			u2a_s3  <= sqa[32:16];
			u2b_s3  <= sqb[32:16];

			c_s4    <= c_s3;  dxn_s4 <= dxn_s3;  dyn_s4 <= dyn_s3;
			quad_s4 <= quad_s3;
			ua_s4   <= ua_s3; ub_s4  <= ub_s3;
			u2a_s4  <= u2a_s3; u2b_s4 <= u2b_s3;
			pa1_s4  <= abs_msd_pkg::SIN_C3 - m5a[29:16];
			pb1_s4  <= abs_msd_pkg::SIN_C3 - m5b[29:16];

			c_s5    <= c_s4;  dxn_s5 <= dxn_s4;  dyn_s5 <= dyn_s4;
			quad_s5 <= quad_s4;
			ua_s5   <= ua_s4; ub_s5  <= ub_s4;
			pa2_s5  <= abs_msd_pkg::SIN_C1 - m3a[32:16];
			pb2_s5  <= abs_msd_pkg::SIN_C1 - m3b[32:16];

			c_s6    <= c_s5;  dxn_s6 <= dxn_s5;  dyn_s6 <= dyn_s5;
			quad_s6 <= quad_s5;
			sa_s6   <= m1a[32:16];
			sb_s6   <= m1b[32:16];
		end
	end

	// ---------------- stage 7: quadrant fold, drift products ----------------
	logic signed [17:0]  sin_v, cos_v, pa_v, pb_v;
	logic signed [42:0]  dpx, dpy;
	carry_t              c_s7;
	logic signed [28:0]  dxn_s7, dyn_s7;
	logic signed [26:0]  dcx_s7, dcy_s7;

	assign pa_v = $signed({1'b0, sa_s6});
	assign pb_v = $signed({1'b0, sb_s6});

	always_comb begin
		unique case (quad_s6)
			2'd0:    begin sin_v = pa_v;  cos_v = pb_v;  end
			2'd1:    begin sin_v = pb_v;  cos_v = -pa_v; end
			2'd2:    begin sin_v = -pa_v; cos_v = -pb_v; end
			default: begin sin_v = -pb_v; cos_v = pa_v;  end
		endcase
	end

	assign dpx = $signed({1'b0, drift_q}) * cos_v;
	assign dpy = $signed({1'b0, drift_q}) * sin_v;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s7   <= c_s6;
			dxn_s7 <= dxn_s6;
			dyn_s7 <= dyn_s6;
			dcx_s7 <= dpx[42:16];
			dcy_s7 <= dpy[42:16];
		end
	end

	// ---------------- stage 8: position update with saturation ----------------
	logic signed [31:0]  x_q, y_q, x_next, y_next;
	logic signed [34:0]  sum_x, sum_y;
	carry_t              c8_in;
	carry_t              c_s8;
	logic signed [31:0]  xb_s8, yb_s8;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647)       return 32'sh7FFFFFFF;
		else if (v < -35'sd2147483648) return 32'sh80000000;
		else                           return v[31:0];
	endfunction

	assign sum_x = 35'(x_q) + 35'(dxn_s7) + 35'(dcx_s7);
	assign sum_y = 35'(y_q) + 35'(dyn_s7) + 35'(dcy_s7);

	always_comb begin
		unique case (c_s7.kind)
			abs_msd_pkg::KIND_STEP: begin x_next = sat32(sum_x); y_next = sat32(sum_y); end
			abs_msd_pkg::KIND_NEW:  begin x_next = '0;           y_next = '0;           end
			default:                begin x_next = x_q;          y_next = y_q;          end
		endcase
	end

	always_comb begin
		c8_in       = c_s7;
		c8_in.pos_x = x_next;
		c8_in.pos_y = y_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (en && stg_vld_q[6]) begin
			x_q <= x_next;
			y_q <= y_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8  <= c8_in;
			xb_s8 <= x_q;
			yb_s8 <= y_q;
		end
	end

	// ---------------- stage 9: squares, memory address ----------------
	logic signed [63:0]  xx, yy;
	carry_t              c_s9;
	logic [62:0]         xx_s9, yy_s9;
	logic [AW-1:0]       addr_s9;
	logic                we_s9;

	assign xx = xb_s8 * xb_s8;
	assign yy = yb_s8 * yb_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s9    <= c_s8;
			xx_s9   <= xx[62:0];
			yy_s9   <= yy[62:0];
			addr_s9 <= (c_s8.kind == abs_msd_pkg::KIND_READ) ? AW'(c_s8.rd_idx) : AW'(c_s8.nb);
			we_s9   <= (c_s8.kind == abs_msd_pkg::KIND_STEP) && !c_s8.ovr;
		end
	end

	// ---------------- stage 10: accumulator read-modify-write ----------------
	logic [62:0]         mem [STEPS];
	logic [62:0]         rdata_q;
	carry_t              c_s10;
	logic [62:0]         xx_s10, yy_s10;
	logic [AW-1:0]       addr_s10;
	logic                we_s10;
	logic [CW-1:0]       fill_q;
	logic                wr_vld_q;
	logic [AW-1:0]       wr_addr_q;
	logic [62:0]         wr_data_q;
	logic [62:0]         cur, cur_ok, sq_sat, acc_new;
	logic [63:0]         sq, tot;
	logic                do_wr;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s10    <= c_s9;
			xx_s10   <= xx_s9;
			yy_s10   <= yy_s9;
			addr_s10 <= addr_s9;
			we_s10   <= we_s9;
		end
	end

	// Read the entry of the item about to enter stage 10; reread while held.
	always_ff @(posedge clk) begin
		rdata_q <= mem[en ? addr_s9 : addr_s10];
		if (do_wr) mem[addr_s10] <= acc_new;
	end

	// Forward the previous write when it hit the same entry; entries at or past
	// the fill count were never written and read as zero.
	assign cur     = (wr_vld_q && wr_addr_q == addr_s10) ? wr_data_q : rdata_q;
	assign cur_ok  = (CW'(addr_s10) < fill_q) ? cur : '0;
	assign sq      = {1'b0, xx_s10} + {1'b0, yy_s10};
	assign sq_sat  = sq[63] ? abs_msd_pkg::ACC_MAX : sq[62:0];
	assign tot     = {1'b0, cur_ok} + {1'b0, sq_sat};
	assign acc_new = tot[63] ? abs_msd_pkg::ACC_MAX : tot[62:0];
	assign do_wr   = en && stg_vld_q[9] && we_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wr_vld_q <= 1'b0;
		end else if (en) begin
			wr_vld_q <= do_wr;
			if (do_wr && CW'(addr_s10) == fill_q) fill_q <= fill_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wr_addr_q <= addr_s10;
			wr_data_q <= acc_new;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			result.pos_x       <= c_s10.pos_x;
			result.pos_y       <= c_s10.pos_y;
			result.heading     <= c_s10.heading;
			result.step_number <= 15'(c_s10.nb);
			result.accum_value <= (c_s10.kind == abs_msd_pkg::KIND_READ && !c_s10.ovr)
				? cur_ok : '0;
			result.overrun     <= c_s10.ovr;
		end
	end

endmodule

FILE: design/abs_msd_chk.sv
// Port-level checker for the active Brownian step block, with its bind.
`include "assert_macros.svh"

module abs_msd_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [3:0]            paddr,
	input logic [31:0]           pwdata,
	input logic [31:0]           prdata,
	input logic                  pready,
	input logic                  item_valid,
	input logic                  item_stall,
	input abs_msd_pkg::item_t    item,
	input logic                  result_valid,
	input logic                  result_stall,
	input abs_msd_pkg::result_t  result
);

	`ABS_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
	`ABS_ASSERT(a_item_hold, item_valid && item_stall |=> item_valid && $stable(item), "stalled item changed")
	`ABS_ASSERT(a_stall_back, result_valid && result_stall |-> item_stall, "item taken while result stalled")
	`ABS_ASSERT(a_reg_readback, psel && penable && pwrite && paddr[3:2] == abs_msd_pkg::REG_TRANS |=> paddr[3:2] != abs_msd_pkg::REG_TRANS || prdata[23:0] == $past(pwdata[23:0]), "register readback mismatch")
	`ABS_ASSERT_ALWAYS(a_prdata_upper, prdata[31:24] == 8'd0 && pready, "register read bits beyond width")

endmodule

bind active_brownian_step_msd_top abs_msd_chk u_abs_msd_chk (.*);

FILE: test/active_brownian_step_msd_top_tb.sv
// Self-checking testbench for the active Brownian step and squared-distance accumulator block.
`timescale 1ns / 1ps

module active_brownian_step_msd_top_tb;

	localparam int STEPS      = abs_msd_pkg::STEPS_DEFAULT;
	localparam int CYCLE_MAX  = 100000;
	localparam int DRAIN_WAIT = 24;
	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [3:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	abs_msd_pkg::item_t   item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	abs_msd_pkg::result_t result;

	active_brownian_step_msd_top #(.STEPS(STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #4 clk = ~clk;

	// Model state: particle, step counter, accumulator memory, registers.
	logic [23:0]      trans_scale, rot_scale, drift_amt;
	logic signed [31:0] px, py;
	logic [31:0]      ang;
	int               step_cnt;
	logic [63:0]      msd_mem [int];
	abs_msd_pkg::result_t pending_results[$];

	int errors = 0;
	int n_items = 0;
	int n_checked = 0;
	int cycles = 0;
	int burst_left = 0;
	bit long_hold_req = 1'b0;

	function automatic longint quarter_wave(longint unsigned u);
		longint unsigned u2, p;
		u2 = (u * u) >> 16;
		p = 64'(abs_msd_pkg::SIN_C3) - ((64'(abs_msd_pkg::SIN_C5) * u2) >> 16);
		p = 64'(abs_msd_pkg::SIN_C1) - ((p * u2) >> 16);
		return longint'((p * u) >> 16);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Advance the particle model by one transaction and return what the block must report.
	function automatic abs_msd_pkg::result_t advance_particle(abs_msd_pkg::item_t it);
		abs_msd_pkg::result_t r;
		longint nx, ny, nh, s, c, a, b, dx, dy, dh, sq_s;
		longint unsigned sq, cur;
		logic [15:0] t;
		r = '0;
		case (abs_msd_pkg::kind_t'(it.kind))
			abs_msd_pkg::KIND_NEW: begin
				px = 0;
				py = 0;
				ang = 0;
				step_cnt = 0;
			end
			abs_msd_pkg::KIND_READ: begin
				if (it.read_index < STEPS)
					r.accum_value = msd_mem.exists(it.read_index) ?
						msd_mem[it.read_index][62:0] : '0;
				else
					r.overrun = 1'b1;
			end
			abs_msd_pkg::KIND_STEP: begin
				r.step_number = step_cnt[14:0];
				if (step_cnt < STEPS) begin
					sq_s = longint'(px) * longint'(px);
					sq = longint'(py) * longint'(py);
					sq = sq + longint'(sq_s);
					cur = msd_mem.exists(step_cnt) ? msd_mem[step_cnt] : 64'd0;
					if (sq > 64'(abs_msd_pkg::ACC_MAX))
						sq = 64'(abs_msd_pkg::ACC_MAX);
					if (cur > 64'(abs_msd_pkg::ACC_MAX) - sq)
						cur = 64'(abs_msd_pkg::ACC_MAX);
					else
						cur = cur + sq;
					msd_mem[step_cnt] = cur;
					step_cnt++;
				end else begin
					r.overrun = 1'b1;
					step_cnt = STEPS;
				end
				nx = longint'(it.noise_x);
				ny = longint'(it.noise_y);
				nh = longint'(it.noise_heading);
				t = ang[29:14];
				a = quarter_wave(64'(t));
				b = quarter_wave(64'd65536 - 64'(t));
				case (ang[31:30])
					2'd0: begin s = a;  c = b;  end
					2'd1: begin s = b;  c = -a; end
					2'd2: begin s = -a; c = -b; end
					default: begin s = -b; c = a; end
				endcase
				dx = ((longint'(trans_scale) * nx) >>> 12) + ((longint'(drift_amt) * c) >>> 16);
				dy = ((longint'(trans_scale) * ny) >>> 12) + ((longint'(drift_amt) * s) >>> 16);
				dh = (longint'(rot_scale) * nh) >>> 4;
				px = 32'(clamp32(longint'(px) + dx));
				py = 32'(clamp32(longint'(py) + dy));
				ang = ang + dh[31:0];
			end
			default: ;
		endcase
		r.pos_x = px;
		r.pos_y = py;
		r.heading = ang;
		if (abs_msd_pkg::kind_t'(it.kind) != abs_msd_pkg::KIND_STEP)
			r.step_number = step_cnt[14:0];
		return r;
	endfunction

	// Offer one transaction; hold it until accepted, then maybe drop valid for a gap.
	task automatic send_item(abs_msd_pkg::item_t it);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(advance_particle(it));
		n_items++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end
	endtask

	function automatic abs_msd_pkg::item_t make_item(abs_msd_pkg::kind_t k, int nx, int ny,
		int nh, int idx);
		abs_msd_pkg::item_t it;
		it.kind = k;
		it.noise_x = 16'(nx);
		it.noise_y = 16'(ny);
		it.noise_heading = 16'(nh);
		it.read_index = 14'(idx);
		return it;
	endfunction

	function automatic abs_msd_pkg::item_t random_step();
		abs_msd_pkg::item_t it;
		it = make_item(abs_msd_pkg::KIND_STEP, $urandom, $urandom, $urandom, $urandom);
		// Mostly moderate x/y samples within +/-12000, sometimes full range.
		if ($urandom_range(0, 3) != 0) begin
			it.noise_x = 16'($signed($urandom_range(0, 24000)) - 12000);
			it.noise_y = 16'($signed($urandom_range(0, 24000)) - 12000);
		end
		return it;
	endfunction

	// Drop valid, let every outstanding result drain, then let the pipeline settle.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [23:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {8'h00, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			abs_msd_pkg::REG_TRANS: trans_scale = val;
			abs_msd_pkg::REG_ROT:   rot_scale = val;
			default:                drift_amt = val;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(logic [1:0] idx, logic [23:0] want);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[23:0] !== want) begin
			errors++;
			$display("%0t readback reg %0d: expected %h, actual %h", $time, idx, want, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_scales(logic [23:0] tr, logic [23:0] ro, logic [23:0] dr);
		wait_idle();
		reg_write(abs_msd_pkg::REG_TRANS, tr);
		reg_write(abs_msd_pkg::REG_ROT, ro);
		reg_write(abs_msd_pkg::REG_DRIFT, dr);
	endtask

	task automatic test_registers();
		reg_check(abs_msd_pkg::REG_TRANS, abs_msd_pkg::TRANS_RESET);
		reg_check(abs_msd_pkg::REG_ROT, abs_msd_pkg::ROT_RESET);
		reg_check(abs_msd_pkg::REG_DRIFT, abs_msd_pkg::DRIFT_RESET);
		set_scales(MAX24, 24'h0, MAX24);
		reg_check(abs_msd_pkg::REG_TRANS, MAX24);
		reg_check(abs_msd_pkg::REG_ROT, 24'h0);
		reg_check(abs_msd_pkg::REG_DRIFT, MAX24);
		set_scales(abs_msd_pkg::TRANS_RESET, abs_msd_pkg::ROT_RESET, abs_msd_pkg::DRIFT_RESET);
	endtask

	// Extremes of each field, every kind, read of never-stepped entries.
	task automatic test_directed();
		send_item(make_item(abs_msd_pkg::KIND_NONE, -1, -1, -1, 16383));
		send_item(make_item(abs_msd_pkg::KIND_READ, 0, 0, 0, 0));
		send_item(make_item(abs_msd_pkg::KIND_READ, 0, 0, 0, 16383));
		send_item(make_item(abs_msd_pkg::KIND_STEP, 0, 0, 0, 0));
		send_item(make_item(abs_msd_pkg::KIND_STEP, 32767, 32767, 32767, 0));
		send_item(make_item(abs_msd_pkg::KIND_STEP, -32768, -32768, -32768, 0));
		send_item(make_item(abs_msd_pkg::KIND_STEP, -1, 1, 16384, 0));
		// Walk the heading through all four quadrants.
		repeat (6) send_item(make_item(abs_msd_pkg::KIND_STEP, 0, 0, 20000, 0));
		send_item(make_item(abs_msd_pkg::KIND_READ, 0, 0, 0, 1));
		send_item(make_item(abs_msd_pkg::KIND_NONE, 0, 0, 0, 0));
		send_item(make_item(abs_msd_pkg::KIND_NEW, 5, 5, 5, 5));
		send_item(make_item(abs_msd_pkg::KIND_STEP, 100, -100, -20000, 0));
		send_item(make_item(abs_msd_pkg::KIND_READ, 0, 0, 0, 0));
	endtask

	// Drive the position to both rails and saturate the accumulator entries
	// stepped while the particle sits on the negative rail.
	task automatic test_saturation();
		set_scales(MAX24, MAX24, MAX24);
		repeat (2) begin
			send_item(make_item(abs_msd_pkg::KIND_NEW, 0, 0, 0, 0));
			repeat (20) send_item(make_item(abs_msd_pkg::KIND_STEP, -32768, -32768, 0, 0));
			repeat (40) send_item(make_item(abs_msd_pkg::KIND_STEP, 32767, 32767, 32767, 0));
		end
		send_item(make_item(abs_msd_pkg::KIND_READ, 0, 0, 0, 1));
		send_item(make_item(abs_msd_pkg::KIND_READ, 0, 0, 0, 20));
		send_item(make_item(abs_msd_pkg::KIND_READ, 0, 0, 0, 60));
	endtask

	task automatic test_random();
		abs_msd_pkg::item_t it;
		logic [23:0] tr, ro, dr;
		int phase;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tr = 24'h0; ro = 24'h0; dr = 24'h0; end
				1: begin
					tr = abs_msd_pkg::TRANS_RESET;
					ro = abs_msd_pkg::ROT_RESET;
					dr = abs_msd_pkg::DRIFT_RESET;
				end
				2: begin tr = MAX24; ro = MAX24; dr = MAX24; end
				default: begin
					tr = 24'($urandom_range(0, 200000));
					ro = 24'($urandom);
					dr = 24'($urandom_range(0, 400000));
				end
			endcase
			set_scales(tr, ro, dr);
			send_item(make_item(abs_msd_pkg::KIND_NEW, 0, 0, 0, 0));
			repeat (75) begin
				case ($urandom_range(0, 19))
					0: it = make_item(abs_msd_pkg::KIND_NEW, $urandom, $urandom, $urandom,
						$urandom);
					1, 2: it = make_item(abs_msd_pkg::KIND_READ, $urandom, $urandom, $urandom,
						$urandom_range(0, step_cnt + 2));
					3: it = make_item(abs_msd_pkg::KIND_READ, $urandom, $urandom, $urandom,
						$urandom);
					4: it = make_item(abs_msd_pkg::KIND_NONE, $urandom, $urandom, $urandom,
						$urandom);
					default: it = random_step();
				endcase
				send_item(it);
			end
		end
	endtask

	// Stop the receiver for a long stretch while items keep coming.
	task automatic test_backpressure();
		set_scales(abs_msd_pkg::TRANS_RESET, abs_msd_pkg::ROT_RESET, abs_msd_pkg::DRIFT_RESET);
		long_hold_req = 1'b1;
		burst_left = 100;
		repeat (60) send_item(random_step());
	endtask

	// Receiver: long hold on request, otherwise a random stall pattern, redrawn each time the phase counter wraps.
	initial begin : receiver
		int hold_left, mode, phase_cnt;
		hold_left = 0;
		mode = 0;
		phase_cnt = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 400;
			end
			if (phase_cnt == 0)
				mode = $urandom_range(0, 2);
			phase_cnt = (phase_cnt + 1) % 64;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (mode == 1) begin
				result_stall <= ($urandom_range(0, 3) == 0);
			end else if (mode == 2) begin
				result_stall <= ($urandom_range(0, 3) != 0);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest pending prediction.
	always @(posedge clk) begin
		abs_msd_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: actual %h", $time, result);
			end else begin
				want = pending_results.pop_front();
				cmp_field("pos_x", 64'(want.pos_x), 64'(result.pos_x));
				cmp_field("pos_y", 64'(want.pos_y), 64'(result.pos_y));
				cmp_field("heading", 64'(want.heading), 64'(result.heading));
				cmp_field("step_number", 64'(want.step_number), 64'(result.step_number));
				cmp_field("accum_value", 64'(want.accum_value), 64'(result.accum_value));
				cmp_field("overrun", 64'(want.overrun), 64'(result.overrun));
				n_checked++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		trans_scale = abs_msd_pkg::TRANS_RESET;
		rot_scale = abs_msd_pkg::ROT_RESET;
		drift_amt = abs_msd_pkg::DRIFT_RESET;
		px = 0;
		py = 0;
		ang = 0;
		step_cnt = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_registers();
		test_directed();
		test_saturation();
		test_random();
		test_backpressure();
		wait_idle();
		$display("Covered register writes and readback, all item kinds, position and");
		$display("accumulator saturation and a long output hold; %0d items sent, %0d results checked.",
			n_items, n_checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: active_brownian_step_msd_top.f
+incdir+design
design/abs_msd_pkg.sv
design/active_brownian_step_msd_top.sv
design/abs_msd_chk.sv
test/active_brownian_step_msd_top_tb.sv
